@@ rtl/ogff_pkg.sv @@
package ogff_pkg;

  // Grid limits
  localparam int MAX_COLS      = 1024;
  localparam int MAX_ROWS      = 1024;
  localparam int MAX_FRONTIERS = 8192;

  localparam int COL_W = $clog2(MAX_COLS);          // column index
  localparam int ROW_W = $clog2(MAX_ROWS);          // row index
  localparam int DIM_W = 11;                        // map_rows / map_cols registers
  localparam int IDX_W = $clog2(MAX_FRONTIERS);     // frontier_index field
  localparam int CNT_W = $clog2(MAX_FRONTIERS) + 1; // counter reaching MAX_FRONTIERS

  // Result queue
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH) + 1;

  // Configuration register indexes
  localparam logic [0:0] REG_MAP_ROWS = 1'b0;
  localparam logic [0:0] REG_MAP_COLS = 1'b1;

  // Input word action codes
  localparam logic ACT_CELL  = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    CLS_OTHER   = 2'd0,
    CLS_FREE    = 2'd1,
    CLS_UNKNOWN = 2'd2
  } cls_e;

  typedef struct packed {
    logic [COL_W-1:0] frontier_x;
    logic [ROW_W-1:0] frontier_y;
    logic [IDX_W-1:0] frontier_index;
  } res_t;

  function automatic cls_e classify(logic signed [7:0] v);
    cls_e r;
    if (v == -8'sd1) begin
      r = CLS_UNKNOWN;
    end else if (v == 8'sd0) begin
      r = CLS_FREE;
    end else begin
      r = CLS_OTHER;
    end
    return r;
  endfunction

  // Zero counts as one, anything above the limit counts as the limit.
  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v,
                                                 logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ rtl/ogff_if.sv @@
interface ogff_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [0:0]                addr;
  logic [ogff_pkg::DIM_W-1:0] data;
  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

interface ogff_in_if;
  logic              valid;
  logic              ready;
  logic              action;
  logic signed [7:0] cell_value;
  modport source (output valid, output action, output cell_value, input ready);
  modport sink   (input valid, input action, input cell_value, output ready);
endinterface

interface ogff_out_if;
  logic                       valid;
  logic                       ready;
  logic [ogff_pkg::COL_W-1:0] frontier_x;
  logic [ogff_pkg::ROW_W-1:0] frontier_y;
  logic [ogff_pkg::IDX_W-1:0] frontier_index;
  modport source (output valid, output frontier_x, output frontier_y,
                  output frontier_index, input ready);
  modport sink   (input valid, input frontier_x, input frontier_y,
                  input frontier_index, output ready);
endinterface

@@ rtl/ogff_res_fifo.sv @@
module ogff_res_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  ogff_pkg::res_t                data_i,
  output logic [ogff_pkg::RES_CNT_W-1:0] count_o,
  ogff_out_if.source                    res_o
);
  import ogff_pkg::*;

  res_t                 mem_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [RES_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [RES_CNT_W-1:0] cnt_q, cnt_d;
  logic                 pop;

  assign pop     = res_o.valid && res_o.ready;
  assign count_o = cnt_q;

  assign res_o.valid          = (cnt_q != '0);
  assign res_o.frontier_x     = mem_q[rd_ptr_q].frontier_x;
  assign res_o.frontier_y     = mem_q[rd_ptr_q].frontier_y;
  assign res_o.frontier_index = mem_q[rd_ptr_q].frontier_index;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + RES_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + RES_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + RES_CNT_W'(push_i) - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/occupancy_grid_frontier_finder.sv @@
// Frontier finder for an occupancy grid, four-neighbor rule.
// cfg_i: register writes (index 0 map_rows, index 1 map_cols), always ready.
//   Write only while the block is idle; both reset to 1024.
// cell_i: one grid cell per word, last row first, left to right in a row.
//   After the last map row the host sends one row of flush words.
// frontier_o: one word per frontier cell: column, row, running index.
// Throughput: one cell word per cycle while ready is high. Each word is one
//   read-modify-write of the two line memories; read issued at acceptance,
//   write-back in the next cycle, with forwarding between back-to-back words.
// Result path: the memory read is registered for stage B's compare, and a hit
//   is registered again by the push into the result queue before frontier_o.
// Decisions lag the input by one row: row r+1 is decided as row r streams in.
// Stall: results queue in a 4-deep FIFO; cell_i drops ready only when the
//   queue plus the word in flight could overflow it.
// Reset: counters cleared, registers at 1024. The line memories are not
//   cleared; row bookkeeping never lets an unwritten entry reach a decision.
module occupancy_grid_frontier_finder (
  input  logic       clk_i,
  input  logic       rst_ni,
  ogff_cfg_if.sink   cfg_i,
  ogff_in_if.sink    cell_i,
  ogff_out_if.source frontier_o
);
  import ogff_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0] map_rows_q, map_cols_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_rows_q <= DIM_W'(MAX_ROWS);
      map_cols_q <= DIM_W'(MAX_COLS);
    end else if (cfg_i.valid) begin
      if (cfg_i.addr == REG_MAP_ROWS) begin
        map_rows_q <= cfg_i.data;
      end else begin
        map_cols_q <= cfg_i.data;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: accept a word, clamp the scan position, issue memory reads
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [COL_W-1:0] col;
    cls_e             cur;
    logic             has_mid;   // a middle row exists (rows_seen >= 1)
    logic             has_old;   // an older row exists (rows_seen >= 2)
    logic             has_right;
    logic             has_left;
    logic [ROW_W-1:0] row_y;
    logic             frame_end;
  } stage_t;

  logic [COL_W-1:0] col_cnt_q, col_cnt_d;
  logic [DIM_W-1:0] rows_seen_q, rows_seen_d;

  logic [DIM_W-1:0] cols_a, rows_a, rs_a;
  logic [COL_W-1:0] c_a, c_nx_a, c_pv_a;
  logic             row_end_a;
  logic             accept;
  stage_t           st_a;

  logic             b_valid_q;
  stage_t           st_b_q;
  logic [RES_CNT_W-1:0] res_cnt;

  // Room check: queue entries plus the word in stage B must leave one slot
  // for the word accepted now.
  assign cell_i.ready = ({1'b0, res_cnt} + (RES_CNT_W + 1)'(b_valid_q))
                        <= (RES_CNT_W + 1)'(RES_DEPTH - 1);
  assign accept = cell_i.valid && cell_i.ready;

  always_comb begin
    cols_a = clamp_dim(map_cols_q, DIM_W'(MAX_COLS));
    rows_a = clamp_dim(map_rows_q, DIM_W'(MAX_ROWS));
    // a counter past the last column (columns shrunk mid-row) saturates
    c_a    = ({1'b0, col_cnt_q} >= cols_a) ? COL_W'(cols_a - DIM_W'(1)) : col_cnt_q;
    rs_a   = (rows_seen_q > rows_a) ? rows_a : rows_seen_q;
    c_nx_a = c_a + COL_W'(1);
    c_pv_a = c_a - COL_W'(1);
    row_end_a = ({1'b0, c_a} + DIM_W'(1)) >= cols_a;

    st_a.col       = c_a;
    // flush row lies outside the grid: everything there is "other"
    st_a.cur       = (rs_a < rows_a && cell_i.action == ACT_CELL)
                     ? classify(cell_i.cell_value) : CLS_OTHER;
    st_a.has_mid   = (rs_a >= DIM_W'(1));
    st_a.has_old   = (rs_a >= DIM_W'(2));
    st_a.has_right = !row_end_a;
    st_a.has_left  = (c_a != '0);
    st_a.row_y     = ROW_W'(rows_a - rs_a);
    st_a.frame_end = row_end_a && (rs_a >= rows_a);

    if (row_end_a) begin
      col_cnt_d   = '0;
      rows_seen_d = st_a.frame_end ? '0 : rs_a + DIM_W'(1);
    end else begin
      col_cnt_d   = c_nx_a;
      rows_seen_d = rs_a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q   <= '0;
      rows_seen_q <= '0;
      b_valid_q   <= 1'b0;
    end else begin
      b_valid_q <= accept;
      if (accept) begin
        col_cnt_q   <= col_cnt_d;
        rows_seen_q <= rows_seen_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line memories: class of each column for the two rows behind the input.
  // Middle is read at c and c+1, older at c and c-1; stage B writes back at c.
  // ---------------------------------------------------------------------------
  cls_e mid_mem [MAX_COLS];
  cls_e old_mem [MAX_COLS];

  cls_e mid_rd0_q, mid_rd1_q, old_rd0_q, old_rd1_q;
  logic fwd_m0_q, fwd_m1_q, fwd_o0_q, fwd_o1_q;
  cls_e fwd_mid_q, fwd_old_q;
  cls_e midc_b, midr_b, oldc_b, oldl_b;

  always_ff @(posedge clk_i) begin
    if (b_valid_q) begin
      old_mem[st_b_q.col] <= midc_b;
      mid_mem[st_b_q.col] <= st_b_q.cur;
    end
    if (accept) begin
      mid_rd0_q <= mid_mem[c_a];
      mid_rd1_q <= mid_mem[c_nx_a];
      old_rd0_q <= old_mem[c_a];
      old_rd1_q <= old_mem[c_pv_a];
    end
  end

  // Forwarding: the read above sees the memory before stage B's write-back
  // of the same edge, so catch address matches against that write.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_b_q    <= st_a;
      fwd_m0_q  <= b_valid_q && (c_a == st_b_q.col);
      fwd_m1_q  <= b_valid_q && (c_nx_a == st_b_q.col);
      fwd_o0_q  <= b_valid_q && (c_a == st_b_q.col);
      fwd_o1_q  <= b_valid_q && (c_pv_a == st_b_q.col);
      fwd_mid_q <= st_b_q.cur;
      fwd_old_q <= midc_b;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: neighbor compare for the middle-row cell, write back, emit
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] frt_cnt_q, frt_cnt_d;
  logic             hit_b, emit_b;
  res_t             res_b;

  always_comb begin
    midc_b = fwd_m0_q ? fwd_mid_q : mid_rd0_q;
    midr_b = fwd_m1_q ? fwd_mid_q : mid_rd1_q;
    oldc_b = fwd_o0_q ? fwd_old_q : old_rd0_q;
    oldl_b = fwd_o1_q ? fwd_old_q : old_rd1_q;

    // neighbors: below (current word), above (older), right (middle), left
    // (older, already shifted down by the previous word of this row)
    hit_b = (st_b_q.cur == CLS_UNKNOWN)
         || (st_b_q.has_old && oldc_b == CLS_UNKNOWN)
         || (st_b_q.has_right && midr_b == CLS_UNKNOWN)
         || (st_b_q.has_left && oldl_b == CLS_UNKNOWN);

    // past capacity frontiers are dropped
    emit_b = b_valid_q && st_b_q.has_mid && (midc_b == CLS_FREE) && hit_b
          && (frt_cnt_q < CNT_W'(MAX_FRONTIERS));

    res_b.frontier_x     = st_b_q.col;
    res_b.frontier_y     = st_b_q.row_y;
    res_b.frontier_index = IDX_W'(frt_cnt_q);

    if (b_valid_q && st_b_q.frame_end) begin
      frt_cnt_d = '0;
    end else begin
      frt_cnt_d = frt_cnt_q + CNT_W'(emit_b);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frt_cnt_q <= '0;
    end else begin
      frt_cnt_q <= frt_cnt_d;
    end
  end

  ogff_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (emit_b),
    .data_i  (res_b),
    .count_o (res_cnt),
    .res_o   (frontier_o)
  );

endmodule

@@ tb/tb_occupancy_grid_frontier_finder.sv @@
module tb_occupancy_grid_frontier_finder;
  import ogff_pkg::*;

  // Size of the random phase, in cell words.
  localparam int unsigned RANDOM_ITEMS = 620;
  // Cycles to wait for outstanding frontier words before calling them lost.
  localparam int unsigned DRAIN_LIMIT  = 4000;
  // Idle cycles after the queue empties: covers pipeline stages A and B.
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned MAX_REPORTS   = 40;

  // Content of the map rows.
  typedef enum int {
    FILL_RANDOM,  // biased mix of unknown / free / occupied / noise
    FILL_DENSE    // one unknown in five, every inner free cell touches one
  } fill_e;

  logic clk_i;
  logic rst_ni;

  ogff_cfg_if cfg_if ();
  ogff_in_if  cell_if ();
  ogff_out_if frontier_if ();

  occupancy_grid_frontier_finder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_if),
    .cell_i     (cell_if),
    .frontier_o (frontier_if)
  );

  // ---------------------------------------------------------------------
  // Mirror of the block: register copies, the two line buffers and the
  // scan position. Updated once per accepted cell word.
  // ---------------------------------------------------------------------
  logic [DIM_W-1:0] rows_reg;
  logic [DIM_W-1:0] cols_reg;
  cls_e             decide_cls  [MAX_COLS];  // row being decided
  cls_e             earlier_cls [MAX_COLS];  // row sent before it
  int unsigned      col_pos;
  int unsigned      rows_done;
  int unsigned      frontier_cnt;

  res_t             frontier_q [$];  // frontier words still to arrive
  int unsigned      mismatch_cnt;
  int unsigned      cells_sent;
  bit               gaps_on;         // random idling on both channels

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin : watchdog
    #80000000;
    $display("Verification failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) begin
      $display("[%0t] MISMATCH: %s", $time, msg);
    end
  endtask

  // Zero means one, anything above the limit means the limit.
  function automatic int unsigned dim_in_use(input logic [DIM_W-1:0] v,
                                             input int unsigned lim);
    if (v == '0) begin
      return 1;
    end
    if (v > lim) begin
      return lim;
    end
    return v;
  endfunction

  function automatic cls_e cell_class(input logic [7:0] v);
    if (v == 8'hFF) begin
      return CLS_UNKNOWN;
    end
    if (v == 8'h00) begin
      return CLS_FREE;
    end
    return CLS_OTHER;
  endfunction

  // Advance the mirror by one cell word; queue a frontier word if one is due.
  task automatic predict_frontier(input logic act, input logic [7:0] val);
    int unsigned cols;
    int unsigned rows;
    int unsigned c;
    cls_e        cur;
    logic        hit;
    res_t        want;
    cols = dim_in_use(cols_reg, MAX_COLS);
    rows = dim_in_use(rows_reg, MAX_ROWS);
    // a shrunk column count ends the row at the new last column
    c = (col_pos >= cols) ? cols - 1 : col_pos;
    // a shrunk row count turns the current row into the flush row
    if (rows_done > rows) begin
      rows_done = rows;
    end
    // flush words, and anything in the flush row, are occupied
    cur = (rows_done < rows && act == ACT_CELL) ? cell_class(val) : CLS_OTHER;
    if (rows_done >= 1 && decide_cls[c] == CLS_FREE) begin
      hit = (cur == CLS_UNKNOWN)
         || (rows_done >= 2 && earlier_cls[c] == CLS_UNKNOWN)
         || (c + 1 < cols && decide_cls[c + 1] == CLS_UNKNOWN)
         || (c > 0 && earlier_cls[c - 1] == CLS_UNKNOWN);
      // past capacity the frontier is dropped and the count holds
      if (hit && frontier_cnt < MAX_FRONTIERS) begin
        want.frontier_x     = COL_W'(c);
        want.frontier_y     = ROW_W'(rows - rows_done);
        want.frontier_index = IDX_W'(frontier_cnt);
        frontier_q.push_back(want);
        frontier_cnt++;
      end
    end
    earlier_cls[c] = decide_cls[c];
    decide_cls[c]  = cur;
    if (c + 1 >= cols) begin
      col_pos = 0;
      rows_done++;
      if (rows_done > rows) begin
        rows_done    = 0;
        frontier_cnt = 0;
      end
    end else begin
      col_pos = c + 1;
    end
  endtask

  // Send one cell word, with an optional idle burst in front of it.
  task automatic send_cell(input logic act, input logic [7:0] val);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      cell_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cell_if.valid      <= 1'b1;
    cell_if.action     <= act;
    cell_if.cell_value <= val;
    @(posedge clk_i);
    while (!cell_if.ready) @(posedge clk_i);
    predict_frontier(act, val);
    cells_sent++;
  endtask

  // Pick the next word from the current scan position and send it.
  task automatic send_next(input fill_e fill);
    int unsigned rows;
    int unsigned cols;
    int unsigned x;
    int unsigned y;
    int unsigned pick;
    logic        act;
    logic [7:0]  val;
    rows = dim_in_use(rows_reg, MAX_ROWS);
    cols = dim_in_use(cols_reg, MAX_COLS);
    x    = (col_pos >= cols) ? cols - 1 : col_pos;
    act  = ACT_CELL;
    val  = 8'h00;
    if (rows_done >= rows) begin
      // flush row: mostly flush words, some map words that must be ignored
      act  = ($urandom_range(0, 5) == 0) ? ACT_CELL : ACT_FLUSH;
      pick = $urandom_range(0, 2);
      val  = (pick == 0) ? 8'hFF : (pick == 1) ? 8'h00 : 8'($urandom);
    end else if (fill == FILL_DENSE) begin
      y   = rows - 1 - rows_done;
      val = ((x + 2 * y) % 5 == 0) ? 8'hFF : 8'h00;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 38) begin
        val = 8'hFF;
      end else if (pick < 72) begin
        val = 8'h00;
      end else if (pick < 87) begin
        val = 8'($urandom_range(1, 100));
      end else if (pick < 94) begin
        val = 8'($urandom);
      end else begin
        // stray flush word inside the map
        act = ACT_FLUSH;
        val = 8'($urandom);
      end
    end
    send_cell(act, val);
  endtask

  // Quiet the cell channel and let every due frontier word come out.
  task automatic settle();
    int unsigned waited;
    cell_if.valid <= 1'b0;
    waited = 0;
    while (frontier_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (frontier_q.size() != 0) begin
      report_mismatch($sformatf("%0d frontier words never arrived",
                                frontier_q.size()));
      frontier_q.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write, only once the block is idle.
  task automatic write_reg(input logic [0:0] idx, input logic [DIM_W-1:0] val);
    settle();
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    if (idx == REG_MAP_ROWS) begin
      rows_reg = val;
    end else begin
      cols_reg = val;
    end
  endtask

  task automatic set_grid(input int unsigned r, input int unsigned c);
    write_reg(REG_MAP_ROWS, DIM_W'(r));
    write_reg(REG_MAP_COLS, DIM_W'(c));
  endtask

  // Stream words until the frame closes. With reshape set, the row count
  // is sometimes rewritten at a row boundary inside the frame.
  task automatic run_frame(input fill_e fill, input bit reshape);
    do begin
      send_next(fill);
      if (reshape && col_pos == 0 && rows_done != 0 && $urandom_range(0, 11) == 0) begin
        write_reg(REG_MAP_ROWS, DIM_W'($urandom_range(0, 6)));
      end
    end while (col_pos != 0 || rows_done != 0);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Column count at its reset value for the start of the only map row,
  // then cut so the row ends early.
  task automatic test_reset_width();
    write_reg(REG_MAP_ROWS, DIM_W'(1));
    repeat (20) send_next(FILL_RANDOM);
    write_reg(REG_MAP_COLS, DIM_W'(12));
    run_frame(FILL_RANDOM, 1'b0);
  endtask

  // 3x4 map by hand: value extremes, a flush word inside the map and
  // map words inside the flush row.
  task automatic test_small_grid();
    logic [7:0]  vals [16] = '{8'h00, 8'hFF, 8'h00, 8'd100,
                               8'hFF, 8'h00, 8'd127, 8'd1,
                               8'h00, 8'h00, 8'h80, 8'h00,
                               8'h00, 8'hFF, 8'h7F, 8'h00};
    logic [15:0] acts = 16'h5200;
    set_grid(3, 4);
    for (int i = 0; i < 16; i++) begin
      send_cell(acts[i] ? ACT_FLUSH : ACT_CELL, vals[i]);
    end
  endtask

  // Smallest grids: each neighbor direction on its own, and 0 meaning 1.
  task automatic test_tiny_grids();
    set_grid(1, 2);
    send_cell(ACT_CELL, 8'h00);
    send_cell(ACT_CELL, 8'hFF);
    send_cell(ACT_FLUSH, 8'h00);
    send_cell(ACT_FLUSH, 8'h00);
    send_cell(ACT_CELL, 8'hFF);
    send_cell(ACT_CELL, 8'h00);
    send_cell(ACT_FLUSH, 8'hFF);
    send_cell(ACT_FLUSH, 8'hFF);
    set_grid(2, 1);
    send_cell(ACT_CELL, 8'h00);
    send_cell(ACT_CELL, 8'hFF);
    send_cell(ACT_FLUSH, 8'h00);
    send_cell(ACT_CELL, 8'hFF);
    send_cell(ACT_CELL, 8'h00);
    send_cell(ACT_FLUSH, 8'h00);
    set_grid(0, 0);
    send_cell(ACT_CELL, 8'h00);
    send_cell(ACT_FLUSH, 8'h00);
    send_cell(ACT_CELL, 8'hFF);
    send_cell(ACT_FLUSH, 8'hFF);
  endtask

  // Column count cut below the column counter in the middle of a row.
  task automatic test_cols_cut_midrow();
    set_grid(3, 6);
    repeat (10) send_next(FILL_RANDOM);
    write_reg(REG_MAP_COLS, DIM_W'(3));
    run_frame(FILL_RANDOM, 1'b0);
  endtask

  // Row count cut below the rows already seen: current row becomes flush.
  task automatic test_rows_cut_midframe();
    set_grid(5, 3);
    repeat (9) send_next(FILL_RANDOM);
    write_reg(REG_MAP_ROWS, DIM_W'(2));
    run_frame(FILL_RANDOM, 1'b0);
  endtask

  // Register extremes: all-ones (clamped) and exactly the limit, each frame
  // cut short; the row-count frames report rows near the top of the index range.
  task automatic test_extreme_dims();
    set_grid(2047, 1);
    repeat (6) send_next(FILL_RANDOM);
    write_reg(REG_MAP_ROWS, DIM_W'(3));
    run_frame(FILL_RANDOM, 1'b0);
    set_grid(1024, 2);
    repeat (8) send_next(FILL_RANDOM);
    write_reg(REG_MAP_ROWS, DIM_W'(2));
    run_frame(FILL_RANDOM, 1'b0);
    set_grid(1, 2047);
    repeat (12) send_next(FILL_RANDOM);
    write_reg(REG_MAP_COLS, DIM_W'(6));
    run_frame(FILL_RANDOM, 1'b0);
  endtask

  // Dense map: most free cells are frontiers, back to back.
  task automatic test_dense_frame();
    set_grid(6, 16);
    run_frame(FILL_DENSE, 1'b0);
  endtask

  // Random grids of mostly small size, random content; idling off at the end.
  task automatic test_random_frames();
    int unsigned start;
    int unsigned r;
    int unsigned c;
    bit          first;
    start = cells_sent;
    first = 1'b1;
    while (cells_sent - start < RANDOM_ITEMS) begin
      if (cells_sent - start > RANDOM_ITEMS * 4 / 5) begin
        gaps_on = 1'b0;
      end
      r = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
      c = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
      if (first) begin
        set_grid(r, c);
        first = 1'b0;
      end else begin
        case ($urandom_range(0, 3))
          0:       write_reg(REG_MAP_ROWS, DIM_W'(r));
          1:       write_reg(REG_MAP_COLS, DIM_W'(c));
          default: set_grid(r, c);
        endcase
      end
      run_frame(FILL_RANDOM, 1'b1);
    end
  endtask

  // ---------------------------------------------------------------------
  // Frontier sink: random backpressure, compare against the oldest
  // expected word.
  // ---------------------------------------------------------------------
  initial begin : frontier_sink
    int unsigned hold;
    res_t        want;
    hold = 0;
    frontier_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (frontier_if.valid && frontier_if.ready) begin
        if (frontier_q.size() == 0) begin
          report_mismatch($sformatf("unexpected frontier word x=%0d y=%0d idx=%0d",
                                    frontier_if.frontier_x, frontier_if.frontier_y,
                                    frontier_if.frontier_index));
        end else begin
          want = frontier_q.pop_front();
          if (frontier_if.frontier_x !== want.frontier_x) begin
            report_mismatch($sformatf("frontier_x got %0d want %0d",
                                      frontier_if.frontier_x, want.frontier_x));
          end
          if (frontier_if.frontier_y !== want.frontier_y) begin
            report_mismatch($sformatf("frontier_y got %0d want %0d",
                                      frontier_if.frontier_y, want.frontier_y));
          end
          if (frontier_if.frontier_index !== want.frontier_index) begin
            report_mismatch($sformatf("frontier_index got %0d want %0d",
                                      frontier_if.frontier_index,
                                      want.frontier_index));
          end
        end
      end
      if (hold != 0) begin
        hold--;
        frontier_if.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 13) - 1;
        frontier_if.ready <= 1'b0;
      end else begin
        frontier_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    rst_ni             <= 1'b0;
    cfg_if.valid       <= 1'b0;
    cfg_if.addr        <= REG_MAP_ROWS;
    cfg_if.data        <= '0;
    cell_if.valid      <= 1'b0;
    cell_if.action     <= ACT_FLUSH;
    cell_if.cell_value <= '0;
    rows_reg     = DIM_W'(MAX_ROWS);
    cols_reg     = DIM_W'(MAX_COLS);
    col_pos      = 0;
    rows_done    = 0;
    frontier_cnt = 0;
    mismatch_cnt = 0;
    cells_sent   = 0;
    gaps_on      = 1'b1;
    foreach (decide_cls[i]) begin
      decide_cls[i]  = CLS_OTHER;
      earlier_cls[i] = CLS_OTHER;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_width();
    test_small_grid();
    test_tiny_grids();
    test_cols_cut_midrow();
    test_rows_cut_midframe();
    test_extreme_dims();
    test_dense_frame();
    test_random_frames();

    settle();
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ occupancy_grid_frontier_finder.f @@
rtl/ogff_pkg.sv
rtl/ogff_if.sv
rtl/ogff_res_fifo.sv
rtl/occupancy_grid_frontier_finder.sv
tb/tb_occupancy_grid_frontier_finder.sv
